// ===== hdl/kli_pkg.sv =====
// Shared constants for the keyframe interpolator.
package kli_pkg;
  localparam logic [2:0] MODE_SET    = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_CLEAR  = 3'd2;
  localparam logic [2:0] MODE_SHIFT  = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;
endpackage

// ===== hdl/kli_ram.sv =====
// Generic single-port RAM with a registered read.
module kli_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hdl/keyframe_linear_interpolator_core.sv =====
// Keyframe table with set, remove, clear, shift and interpolating query.
// Every request except clear and unused modes scans all slots, issuing a read in S_SCAN
// and inspecting it in S_EVAL for each slot. Set and remove then edit the table, and a query
// reads the bracketing values and finishes in a restoring divider; clear and unused modes
// go straight to the result. One request at a time; the result register holds
// until taken. Reset clears all valid bits at once; key and value memories are not cleared.
module keyframe_linear_interpolator_core import kli_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         mode_i,
  input  logic [15:0]        key_time_i,
  input  logic signed [15:0] key_value_i,
  input  logic signed [15:0] shift_amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] interp_value_o,
  output logic [15:0]        next_key_o,
  output logic [15:0]        prev_key_o,
  output logic               table_empty_o,
  output logic               table_full_error_o
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LastIdx = CW'(TABLE_DEPTH - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // issue read of slot
  localparam logic [3:0] S_EVAL  = 4'd2;  // inspect read data
  localparam logic [3:0] S_EDIT  = 4'd3;
  localparam logic [3:0] S_RDA   = 4'd4;  // read value at before
  localparam logic [3:0] S_RDB   = 4'd5;  // read value at after
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_RDL   = 4'd10;

  logic [3:0] st_q, st_d;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [2:0]  mode_q;
  logic [15:0] t_q;
  logic signed [15:0] v_q, d_q;
  logic [CW-1:0] idx_q;
  logic [AW-1:0] rd_idx_q;

  // Scan results
  logic hit_q, free_q, aft_ok_q, abv_ok_q, bef_ok_q, lst_ok_q, fst_eq_aft_q;
  logic [AW-1:0] hit_i_q, free_i_q, aft_i_q, bef_i_q, lst_i_q;
  logic [15:0] aft_k_q, abv_k_q, bef_k_q, lst_k_q, fst_k_q;
  logic signed [15:0] a_q, b_q;

  // Divider
  logic signed [33:0] num_q;
  logic [33:0] rem_q, quo_q;
  logic [16:0] den_q;
  logic neg_q;
  logic [5:0] cnt_q;

  logic [15:0] key_rd, val_rd;
  logic key_we, val_we;
  logic [AW-1:0] addr;
  logic [15:0] val_wd;

  logic signed [15:0] res_v_q;
  logic [15:0] res_n_q, res_p_q;
  logic res_e_q, res_f_q;

  kli_ram #(.Width(16), .Depth(TABLE_DEPTH)) u_keys (
    .clk_i(clk_i), .we_i(key_we), .addr_i(addr), .wdata_i(t_q), .rdata_o(key_rd)
  );
  kli_ram #(.Width(16), .Depth(TABLE_DEPTH)) u_vals (
    .clk_i(clk_i), .we_i(val_we), .addr_i(addr), .wdata_i(val_wd), .rdata_o(val_rd)
  );

  assign in_stall_o = (st_q != S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign interp_value_o = res_v_q;
  assign next_key_o = res_n_q;
  assign prev_key_o = res_p_q;
  assign table_empty_o = res_e_q;
  assign table_full_error_o = res_f_q;

  logic slot_v;
  assign slot_v = valid_q[rd_idx_q];
  logic signed [16:0] sat_sum;
  assign sat_sum = 17'($signed(val_rd)) + 17'(d_q);
  // Saturate the shifted value to 16 bits.
  always_comb begin
    val_wd = v_q;
    if (mode_q == MODE_SHIFT) begin
      if (sat_sum > 17'sd32767) val_wd = 16'sh7fff;
      else if (sat_sum < -17'sd32768) val_wd = 16'sh8000;
      else val_wd = sat_sum[15:0];
    end
  end

  logic edit_set_new;
  assign edit_set_new = (st_q == S_EDIT) && (mode_q == MODE_SET) && !hit_q && free_q;
  assign key_we = edit_set_new;
  assign val_we = ((st_q == S_EDIT) && (mode_q == MODE_SET) && (hit_q || free_q)) ||
                  ((st_q == S_EVAL) && (mode_q == MODE_SHIFT) && slot_v);
  always_comb begin
    addr = idx_q[AW-1:0];
    unique case (st_q)
      S_EVAL: addr = rd_idx_q;
      S_EDIT: addr = hit_q ? hit_i_q : free_i_q;
      S_RDA:  addr = bef_i_q;
      S_RDB:  addr = aft_i_q;
      S_RDL:  addr = lst_i_q;
      default: addr = idx_q[AW-1:0];
    endcase
  end

  logic [33:0] rem_sh;
  assign rem_sh = {rem_q[32:0], quo_q[33]};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (in_valid_i) begin
        if (mode_i == MODE_CLEAR || mode_i > MODE_QUERY) st_d = S_OUT;
        else st_d = S_SCAN;
      end
      S_SCAN: st_d = S_EVAL;
      S_EVAL: begin
        if (idx_q > LastIdx) begin
          unique case (mode_q)
            MODE_SET, MODE_REMOVE: st_d = S_EDIT;
            MODE_QUERY: st_d = S_RDL;
            default: st_d = S_OUT;
          endcase
        end else st_d = S_SCAN;
      end
      S_EDIT: st_d = S_OUT;
      S_RDL:  st_d = S_RDA;
      S_RDA:  st_d = S_RDB;
      S_RDB:  st_d = S_MUL;
      S_MUL:  st_d = S_DIV;
      S_DIV:  if (cnt_q == 6'd34) st_d = S_FIN;
      S_FIN:  st_d = S_OUT;
      S_OUT:  if (!out_stall_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      valid_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == S_IDLE && in_valid_i && mode_i == MODE_CLEAR) valid_q <= '0;
      if (edit_set_new) valid_q[free_i_q] <= 1'b1;
      if (st_q == S_EDIT && mode_q == MODE_REMOVE && hit_q) valid_q[hit_i_q] <= 1'b0;
    end
  end

  logic [15:0] lo_v_q;
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        mode_q <= mode_i; t_q <= key_time_i; v_q <= key_value_i; d_q <= shift_amount_i;
        idx_q <= '0;
        hit_q <= 1'b0; free_q <= 1'b0; aft_ok_q <= 1'b0; abv_ok_q <= 1'b0;
        bef_ok_q <= 1'b0; lst_ok_q <= 1'b0; res_f_q <= 1'b0;
        res_v_q <= '0; res_n_q <= '0; res_p_q <= '0;
        res_e_q <= (mode_i == MODE_CLEAR) ? 1'b1 : (valid_q == '0);
      end
      S_SCAN: begin
        rd_idx_q <= idx_q[AW-1:0];
        idx_q <= idx_q + CW'(1);
      end
      S_EVAL: begin
        if (slot_v) begin
          if (key_rd == t_q) begin hit_q <= 1'b1; hit_i_q <= rd_idx_q; end
          if (!lst_ok_q || key_rd > lst_k_q) begin
            lst_ok_q <= 1'b1; lst_k_q <= key_rd; lst_i_q <= rd_idx_q;
          end
          if (!lst_ok_q || key_rd < fst_k_q) fst_k_q <= key_rd;
          if (key_rd >= t_q && (!aft_ok_q || key_rd < aft_k_q)) begin
            aft_ok_q <= 1'b1; aft_k_q <= key_rd; aft_i_q <= rd_idx_q;
          end
          if (key_rd > t_q && (!abv_ok_q || key_rd < abv_k_q)) begin
            abv_ok_q <= 1'b1; abv_k_q <= key_rd;
          end
          if (key_rd < t_q && (!bef_ok_q || key_rd > bef_k_q)) begin
            bef_ok_q <= 1'b1; bef_k_q <= key_rd; bef_i_q <= rd_idx_q;
          end
        end else if (!free_q) begin
          free_q <= 1'b1; free_i_q <= rd_idx_q;
        end
      end
      S_EDIT: begin
        res_f_q <= (mode_q == MODE_SET) && !hit_q && !free_q;
        if (mode_q == MODE_SET && (hit_q || free_q)) res_e_q <= 1'b0;
        else if (mode_q == MODE_REMOVE && hit_q)
          res_e_q <= ((valid_q & ~(TABLE_DEPTH'(1) << hit_i_q)) == '0);
      end
      S_RDL: fst_eq_aft_q <= (fst_k_q == aft_k_q);
      S_RDA: lo_v_q <= val_rd;  // value at the last key
      S_RDB: a_q <= val_rd;
      S_MUL: begin
        b_q <= val_rd;
        res_n_q <= abv_ok_q ? abv_k_q : (lst_ok_q ? lst_k_q : 16'd0);
        res_p_q <= bef_ok_q ? bef_k_q : 16'd0;
        num_q <= 34'(a_q * $signed({1'b0, aft_k_q - t_q})) +
                 34'($signed(val_rd) * $signed({1'b0, t_q - bef_k_q}));
        den_q <= {1'b0, aft_k_q - bef_k_q};
        cnt_q <= '0;
        rem_q <= '0;
      end
      S_DIV: begin
        if (cnt_q == 6'd0) begin
          neg_q <= num_q[33];
          quo_q <= num_q[33] ? 34'(-num_q) : num_q;
          cnt_q <= cnt_q + 6'd1;
        end else begin
          if (rem_sh >= 34'(den_q)) begin
            rem_q <= rem_sh - 34'(den_q);
            quo_q <= {quo_q[32:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[32:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
        end
      end
      S_FIN: begin
        if (!lst_ok_q) res_v_q <= '0;
        else if (!aft_ok_q) res_v_q <= lo_v_q;
        else if (aft_k_q == t_q || fst_eq_aft_q || !bef_ok_q) res_v_q <= b_q;
        else res_v_q <= (neg_q ? 16'(-quo_q) : quo_q[15:0]) & 16'hfffe;
      end
      default: ;
    endcase
  end
endmodule

// ===== tb/sv/keyframe_linear_interpolator_core_tb.sv =====
// Self-checking testbench for the keyframe interpolator core with its own table model.
module keyframe_linear_interpolator_core_tb import kli_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic signed [15:0] value;
    logic [15:0]        next_key;
    logic [15:0]        prev_key;
    logic               empty;
    logic               full_err;
  } frame_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         mode_i = MODE_QUERY;
  logic [15:0]        key_time_i = '0;
  logic signed [15:0] key_value_i = '0;
  logic signed [15:0] shift_amount_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] interp_value_o;
  logic [15:0]        next_key_o;
  logic [15:0]        prev_key_o;
  logic               table_empty_o;
  logic               table_full_error_o;

  keyframe_linear_interpolator_core #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the keyframe table.
  logic [15:0]        shadow_keys [DEPTH];
  logic signed [15:0] shadow_vals [DEPTH];
  logic               shadow_used [DEPTH];

  frame_result_t pending_results[$];
  int  error_count = 0;
  int  sent_count = 0;
  int  checked_count = 0;
  int  query_count = 0;
  int  interp_count = 0;
  int  full_count = 0;
  int  burst_left = 0;
  int  hold_request = 0;
  bit  no_idle = 1'b0;

  function automatic int find_slot(logic [15:0] k);
    for (int i = 0; i < DEPTH; i++)
      if (shadow_used[i] && shadow_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic frame_result_t predict_request(logic [2:0] mode, logic [15:0] t,
                                                    logic signed [15:0] v,
                                                    logic signed [15:0] d);
    frame_result_t r;
    int slot;
    int s;
    bit any, has_after, has_above, has_before;
    logic [15:0] k_first, k_last, k_after, k_above, k_before;
    logic signed [15:0] v_last, v_after, v_before;
    longint num, q;
    r = '0;
    any = 0; has_after = 0; has_above = 0; has_before = 0;
    k_first = 0; k_last = 0; k_after = 0; k_above = 0; k_before = 0;
    v_last = 0; v_after = 0; v_before = 0;
    case (mode)
      MODE_SET: begin
        slot = find_slot(t);
        if (slot < 0) begin
          for (int i = 0; i < DEPTH; i++)
            if (!shadow_used[i]) begin
              slot = i;
              break;
            end
          if (slot < 0) r.full_err = 1'b1;
          else begin
            shadow_used[slot] = 1'b1;
            shadow_keys[slot] = t;
          end
        end
        if (slot >= 0) shadow_vals[slot] = v;
      end
      MODE_REMOVE: begin
        slot = find_slot(t);
        if (slot >= 0) shadow_used[slot] = 1'b0;
      end
      MODE_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) shadow_used[i] = 1'b0;
      end
      MODE_SHIFT: begin
        for (int i = 0; i < DEPTH; i++)
          if (shadow_used[i]) begin
            s = int'(shadow_vals[i]) + int'(d);
            if (s > 32767) s = 32767;
            if (s < -32768) s = -32768;
            shadow_vals[i] = 16'(s);
          end
      end
      MODE_QUERY: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!shadow_used[i]) continue;
          if (!any || shadow_keys[i] < k_first) k_first = shadow_keys[i];
          if (!any || shadow_keys[i] > k_last) begin
            k_last = shadow_keys[i];
            v_last = shadow_vals[i];
          end
          any = 1;
          if (shadow_keys[i] >= t && (!has_after || shadow_keys[i] < k_after)) begin
            has_after = 1;
            k_after = shadow_keys[i];
            v_after = shadow_vals[i];
          end
          if (shadow_keys[i] > t && (!has_above || shadow_keys[i] < k_above)) begin
            has_above = 1;
            k_above = shadow_keys[i];
          end
          if (shadow_keys[i] < t && (!has_before || shadow_keys[i] > k_before)) begin
            has_before = 1;
            k_before = shadow_keys[i];
            v_before = shadow_vals[i];
          end
        end
        if (any) begin
          r.next_key = has_above ? k_above : k_last;
          r.prev_key = has_before ? k_before : 16'd0;
          if (!has_after) r.value = v_last;
          else if (k_after == t || !has_before) r.value = v_after;
          else begin
            num = longint'(v_before) * (longint'(k_after) - longint'(t))
                + longint'(v_after) * (longint'(t) - longint'(k_before));
            q = num / (longint'(k_after) - longint'(k_before));
            r.value = q[15:0] & 16'hFFFE;
            interp_count++;
          end
        end
      end
      default: ;
    endcase
    r.empty = 1'b1;
    for (int i = 0; i < DEPTH; i++)
      if (shadow_used[i]) r.empty = 1'b0;
    return r;
  endfunction

  // Sends one request; the sender works in bursts with random gaps in between unless no_idle is set.
  task automatic send_request(logic [2:0] mode, logic [15:0] t,
                              logic signed [15:0] v, logic signed [15:0] d);
    int gap;
    if (!no_idle && burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    key_time_i     <= t;
    key_value_i    <= v;
    shift_amount_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_request(mode, t, v, d));
    sent_count++;
    if (mode == MODE_QUERY) query_count++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall pattern, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      out_stall_i <= 1'b1;
      hold_request <= hold_request - 1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 30);
    end
  end

  always @(posedge clk_i) begin
    frame_result_t exp_r;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected (value %0d)", $time, interp_value_o);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_count++;
        if (interp_value_o !== exp_r.value) begin
          $display("%0t: interp_value expected %0d actual %0d", $time, exp_r.value,
                   interp_value_o);
          error_count++;
        end
        if (next_key_o !== exp_r.next_key) begin
          $display("%0t: next_key expected %0d actual %0d", $time, exp_r.next_key,
                   next_key_o);
          error_count++;
        end
        if (prev_key_o !== exp_r.prev_key) begin
          $display("%0t: prev_key expected %0d actual %0d", $time, exp_r.prev_key,
                   prev_key_o);
          error_count++;
        end
        if (table_empty_o !== exp_r.empty) begin
          $display("%0t: table_empty expected %0b actual %0b", $time, exp_r.empty,
                   table_empty_o);
          error_count++;
        end
        if (table_full_error_o !== exp_r.full_err) begin
          $display("%0t: table_full_error expected %0b actual %0b", $time, exp_r.full_err,
                   table_full_error_o);
          error_count++;
        end
        if (exp_r.full_err) full_count++;
      end
    end
  end

  task automatic test_directed();
    send_request(MODE_QUERY, 16'd100, 0, 0);          // empty table
    send_request(MODE_SHIFT, 0, 0, 16'sd5);           // shift on empty table
    send_request(MODE_REMOVE, 16'd7, 0, 0);           // remove of absent key
    send_request(MODE_SET, 16'd0, -16'sd32768, 0);
    send_request(MODE_SET, 16'd65535, 16'sd32767, 0);
    send_request(MODE_QUERY, 16'd32768, 0, 0);
    send_request(MODE_SET, 16'd1000, 16'sd100, 0);
    send_request(MODE_SET, 16'd1000, -16'sd100, 0);   // overwrite existing key
    send_request(MODE_QUERY, 16'd1000, 0, 0);
    send_request(MODE_QUERY, 16'd500, 0, 0);
    send_request(MODE_QUERY, 16'd65535, 0, 0);
    send_request(MODE_QUERY, 16'd0, 0, 0);
    send_request(MODE_SHIFT, 0, 0, 16'sd32767);       // saturate high
    send_request(MODE_QUERY, 16'd3, 0, 0);
    send_request(MODE_SHIFT, 0, 0, -16'sd32768);      // saturate low
    send_request(MODE_SHIFT, 0, 0, -16'sd32768);
    send_request(MODE_QUERY, 16'd40000, 0, 0);
    send_request(MODE_REMOVE, 16'd65535, 0, 0);
    send_request(MODE_QUERY, 16'd65000, 0, 0);        // past the last key
    send_request(3'd5, 16'hFFFF, -1, -1);
    send_request(3'd6, 0, 0, 0);
    send_request(3'd7, 16'h1234, 16'sh5678, 0);
    send_request(MODE_CLEAR, 0, 0, 0);
    send_request(MODE_QUERY, 16'd1, 0, 0);
    wait_drained();
  endtask

  task automatic test_table_full();
    send_request(MODE_CLEAR, 0, 0, 0);
    for (int i = 0; i < DEPTH; i++)
      send_request(MODE_SET, 16'(i * 1000 + 3), 16'($urandom), 0);
    send_request(MODE_SET, 16'd1, 16'sd9, 0);         // new key, no free slot
    send_request(MODE_SET, 16'd3003, 16'sd9, 0);      // existing key, still fine
    send_request(MODE_QUERY, 16'd3500, 0, 0);
    send_request(MODE_REMOVE, 16'd5003, 0, 0);
    send_request(MODE_SET, 16'd1, 16'sd9, 0);         // slot freed again
    send_request(MODE_SET, 16'd2, 16'sd9, 0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_request <= 600;
    for (int i = 0; i < 12; i++)
      send_request((i % 3 == 0) ? MODE_SET : MODE_QUERY, 16'($urandom_range(0, 400)),
                   16'($urandom), 0);
    wait_drained();
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++)
      send_request((i % 2) ? MODE_QUERY : MODE_SET, 16'($urandom_range(0, 2000)),
                   16'($urandom), 0);
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Mostly well-formed build-and-query traffic with some edits and noise.
  task automatic test_random(int count);
    logic [2:0]  mode;
    logic [15:0] t;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) mode = MODE_SET;
      else if (pick < 75) mode = MODE_QUERY;
      else if (pick < 87) mode = MODE_REMOVE;
      else if (pick < 95) mode = MODE_SHIFT;
      else if (pick < 97) mode = MODE_CLEAR;
      else mode = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 3) == 0) t = 16'($urandom);
      else t = 16'($urandom_range(0, 300));
      send_request(mode, t, 16'($urandom),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40) - 20));
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_used[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    test_no_idle();
    test_random(1200);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d requests (%0d queries, %0d interpolated, %0d full-table sets),",
             sent_count, query_count, interp_count, full_count);
    $display("checked %0d results, %0d mismatches.", checked_count, error_count);
    if (error_count == 0 && pending_results.size() == 0)
      $display("keyframe_linear_interpolator_core_tb: clean");
    else
      $display("keyframe_linear_interpolator_core_tb: errors");
    $finish;
  end

  initial begin
    #60ms;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("keyframe_linear_interpolator_core_tb: errors");
    $finish;
  end

endmodule
